FILE: hw/rtl/contact_collision_response_unit_assert.svh
// ----------------------------------------------------------------------------
// contact collision response assertion macros
// shared assertion forms for the contact collision response block
// ----------------------------------------------------------------------------
`ifndef CONTACT_COLLISION_RESPONSE_UNIT_ASSERT_SVH
`define CONTACT_COLLISION_RESPONSE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CCRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CCRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/ccru_pkg.sv
// ----------------------------------------------------------------------------
// ccru_pkg
// types, stage map and helpers of the contact collision response pipeline
// ----------------------------------------------------------------------------
package ccru_pkg;

	// body kind and shape codes
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_DYNAMIC = 2'd3;
	localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
	localparam logic [1:0] SHAPE_RECT   = 2'd1;

	// momentum weight used when both masses are zero (one half in q1.31)
	localparam logic [31:0] W_HALF = 32'h4000_0000;

	// stage map
	localparam int N_ISQ    = 32;
	localparam int N_DIV    = 31;
	localparam int ST_SQR   = 2;
	localparam int ST_SUM   = 3;
	localparam int ST_ISQ0  = 4;
	localparam int ST_DIV0  = ST_ISQ0 + N_ISQ;
	localparam int ST_MUL   = ST_DIV0 + N_DIV;
	localparam int ST_DOT   = ST_MUL + 1;
	localparam int ST_CMUL  = ST_DOT + 1;
	localparam int ST_CORR  = ST_CMUL + 1;
	localparam int ST_DIFF  = ST_CORR + 1;
	localparam int ST_BMUL  = ST_DIFF + 1;
	localparam int N_STG    = ST_BMUL + 1;

	// context carried down the pipeline
	typedef struct packed {
		logic               mov_a;
		logic               mov_b;
		logic               has_both;
		logic               strip_on;
		logic               strip_b;
		logic signed [31:0] va_x;
		logic signed [31:0] va_y;
		logic signed [31:0] vb_x;
		logic signed [31:0] vb_y;
		logic signed [31:0] t_x;
		logic signed [31:0] t_y;
		logic signed [31:0] sh_ax;
		logic signed [31:0] sh_ay;
		logic signed [31:0] sh_bx;
		logic signed [31:0] sh_by;
		logic [32:0]        msum;
		logic [63:0]        mrem;
		logic [31:0]        w;
		logic [63:0]        sqx;
		logic [63:0]        sqy;
		logic [63:0]        sq_n;
		logic [63:0]        sq_res;
		logic               sq_zero;
		logic [63:0]        rem_x;
		logic [63:0]        rem_y;
		logic [30:0]        q_x;
		logic [30:0]        q_y;
		logic signed [31:0] n_x;
		logic signed [31:0] n_y;
		logic signed [63:0] p_x;
		logic signed [63:0] p_y;
		logic               dot_pos;
		logic [32:0]        into;
		logic signed [65:0] c_x;
		logic signed [65:0] c_y;
		logic signed [32:0] d_x;
		logic signed [32:0] d_y;
		logic signed [65:0] b_x;
		logic signed [65:0] b_y;
	} ctx_t;

	// negate with saturation
	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		if (v == 32'sh8000_0000)
			return 32'sh7fff_ffff;
		return -v;
	endfunction

	// clamp to 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -66'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// magnitude of a signed word, exact for the most negative value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

endpackage

FILE: hw/rtl/contact_collision_response_unit.sv
// ----------------------------------------------------------------------------
// contact_collision_response_unit
// resolves one 2d contact per beat: normal strip, position split, momentum
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_stall carries one contact per beat (velocities,
//   masses, kinds, shapes, translation vector); output channel
//   out_valid/out_stall carries the new velocities and position shifts.
//   A beat moves when valid is high and stall is low.
// Depth: set by the pipelined square root (32 stages, one root bit each),
//   the two normal dividers (31 stages, one quotient bit each) that
//   follow it, and the multiply stages; the mass-weight divider runs
//   alongside the root stages.
// Throughput: one contact per cycle while the output beat is not held
//   by out_stall.
// Reset: arst_n clears all valid bits at once; the pipeline is empty and
//   ready in the first cycle after release.
// Stall: while the output beat is held by out_stall the whole pipeline
//   freezes and in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "contact_collision_response_unit_assert.svh"

module contact_collision_response_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vel_a_x,
	input  logic signed [31:0] vel_a_y,
	input  logic signed [31:0] vel_b_x,
	input  logic signed [31:0] vel_b_y,
	input  logic [31:0]        mass_a,
	input  logic [31:0]        mass_b,
	input  logic [1:0]         kind_a,
	input  logic [1:0]         kind_b,
	input  logic [1:0]         shape_a,
	input  logic [1:0]         shape_b,
	input  logic signed [31:0] mtv_x,
	input  logic signed [31:0] mtv_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_vel_a_x,
	output logic signed [31:0] new_vel_a_y,
	output logic signed [31:0] new_vel_b_x,
	output logic signed [31:0] new_vel_b_y,
	output logic signed [31:0] shift_a_x,
	output logic signed [31:0] shift_a_y,
	output logic signed [31:0] shift_b_x,
	output logic signed [31:0] shift_b_y
);
	import ccru_pkg::*;

	ctx_t             stg_s [1:N_STG];
	ctx_t             nxt   [1:N_STG];
	logic [N_STG:1]   vld_s;
	logic             adv;

	// global advance: freeze everything while the output beat is held
	assign adv      = !(vld_s[N_STG] && out_stall);
	assign in_stall = !adv;

	// entry stage: separation sign, movers, shifts, divider setup
	always_comb begin
		ctx_t               c;
		logic               neg;
		logic signed [31:0] s_x;
		logic signed [31:0] s_y;
		logic signed [32:0] h_x;
		logic signed [32:0] h_y;
		c          = '0;
		neg        = (shape_a == SHAPE_CIRCLE || shape_a == SHAPE_RECT)
			&& shape_b == SHAPE_RECT;
		s_x        = neg ? neg_sat(mtv_x) : mtv_x;
		s_y        = neg ? neg_sat(mtv_y) : mtv_y;
		h_x        = (33'(s_x) + 33'(s_x[31])) >>> 1;
		h_y        = (33'(s_y) + 33'(s_y[31])) >>> 1;
		c.mov_a    = kind_a == KIND_DYNAMIC;
		c.mov_b    = kind_b == KIND_DYNAMIC;
		c.has_both = kind_a != KIND_NONE && kind_b != KIND_NONE;
		c.strip_on = c.mov_a ^ c.mov_b;
		c.strip_b  = c.mov_b;
		c.va_x     = vel_a_x;
		c.va_y     = vel_a_y;
		c.vb_x     = vel_b_x;
		c.vb_y     = vel_b_y;
		c.t_x      = c.mov_b ? neg_sat(s_x) : s_x;
		c.t_y      = c.mov_b ? neg_sat(s_y) : s_y;
		if (c.mov_a && c.mov_b) begin
			c.sh_ax = -h_x[31:0];
			c.sh_ay = -h_y[31:0];
			c.sh_bx = h_x[31:0];
			c.sh_by = h_y[31:0];
		end else if (c.mov_a) begin
			c.sh_ax = neg_sat(s_x);
			c.sh_ay = neg_sat(s_y);
		end else if (c.mov_b) begin
			c.sh_bx = s_x;
			c.sh_by = s_y;
		end
		c.msum = {1'b0, mass_a} + {1'b0, mass_b};
		c.mrem = {1'b0, mass_b, 31'b0};
		nxt[1] = c;
	end

	// remaining stages
	for (genvar g = 2; g <= N_STG; g++) begin : g_stage
		if (g == ST_SQR) begin : g_sqr
			// squares of the separation magnitude, divider dividends
			always_comb begin
				ctx_t        c;
				logic [31:0] m_x;
				logic [31:0] m_y;
				c       = stg_s[g-1];
				m_x     = mag32(c.t_x);
				m_y     = mag32(c.t_y);
				c.sqx   = {32'b0, m_x} * {32'b0, m_x};
				c.sqy   = {32'b0, m_y} * {32'b0, m_y};
				c.rem_x = {2'b0, m_x, 30'b0};
				c.rem_y = {2'b0, m_y, 30'b0};
				c.q_x   = '0;
				c.q_y   = '0;
				nxt[g]  = c;
			end
		end else if (g == ST_SUM) begin : g_sum
			// squared length
			always_comb begin
				ctx_t c;
				c         = stg_s[g-1];
				c.sq_n    = c.sqx + c.sqy;
				c.sq_res  = '0;
				c.sq_zero = c.sq_n == 64'd0;
				nxt[g]    = c;
			end
		end else if (g < ST_DIV0) begin : g_isq
			// one root bit and one mass-weight quotient bit
			localparam int I = g - ST_ISQ0;
			localparam int K = 31 - I;
			always_comb begin
				ctx_t        c;
				logic [63:0] rb;
				logic [63:0] trial;
				logic [63:0] dv;
				c     = stg_s[g-1];
				rb    = 64'd1 << (62 - 2 * I);
				trial = c.sq_res + rb;
				if (c.sq_n >= trial) begin
					c.sq_n   = c.sq_n - trial;
					c.sq_res = (c.sq_res >> 1) + rb;
				end else begin
					c.sq_res = c.sq_res >> 1;
				end
				dv = {31'b0, c.msum} << K;
				if (c.mrem >= dv) begin
					c.mrem = c.mrem - dv;
					c.w[K] = 1'b1;
				end
				nxt[g] = c;
			end
		end else if (g < ST_MUL) begin : g_div
			// one quotient bit of each normal component
			localparam int K = 30 - (g - ST_DIV0);
			always_comb begin
				ctx_t        c;
				logic [63:0] dl;
				c  = stg_s[g-1];
				dl = {32'b0, c.sq_res[31:0]} << K;
				if (c.rem_x >= dl) begin
					c.rem_x  = c.rem_x - dl;
					c.q_x[K] = 1'b1;
				end
				if (c.rem_y >= dl) begin
					c.rem_y  = c.rem_y - dl;
					c.q_y[K] = 1'b1;
				end
				nxt[g] = c;
			end
		end else if (g == ST_MUL) begin : g_mul
			// signed normal, velocity times normal, weight for zero total mass
			always_comb begin
				ctx_t               c;
				logic signed [31:0] v_x;
				logic signed [31:0] v_y;
				c     = stg_s[g-1];
				c.n_x = c.t_x[31] ? -$signed({1'b0, c.q_x}) : $signed({1'b0, c.q_x});
				c.n_y = c.t_y[31] ? -$signed({1'b0, c.q_y}) : $signed({1'b0, c.q_y});
				v_x   = c.strip_b ? c.vb_x : c.va_x;
				v_y   = c.strip_b ? c.vb_y : c.va_y;
				c.p_x = 64'(v_x) * 64'(c.n_x);
				c.p_y = 64'(v_y) * 64'(c.n_y);
				if (c.msum == 33'd0)
					c.w = W_HALF;
				nxt[g] = c;
			end
		end else if (g == ST_DOT) begin : g_dot
			// dot product and the component into the normal
			always_comb begin
				ctx_t               c;
				logic signed [63:0] dot;
				c         = stg_s[g-1];
				dot       = c.p_x + c.p_y;
				c.dot_pos = !dot[63] && dot != 64'sd0;
				c.into    = dot[62:30];
				nxt[g]    = c;
			end
		end else if (g == ST_CMUL) begin : g_cmul
			// normal times into
			always_comb begin
				ctx_t c;
				c      = stg_s[g-1];
				c.c_x  = 66'(c.n_x) * 66'($signed({1'b0, c.into}));
				c.c_y  = 66'(c.n_y) * 66'($signed({1'b0, c.into}));
				nxt[g] = c;
			end
		end else if (g == ST_CORR) begin : g_corr
			// apply correction to the single movable body
			always_comb begin
				ctx_t               c;
				logic signed [65:0] k_x;
				logic signed [65:0] k_y;
				logic signed [65:0] v_x;
				logic signed [65:0] v_y;
				logic signed [31:0] r_x;
				logic signed [31:0] r_y;
				c   = stg_s[g-1];
				k_x = c.c_x[65] ? ((c.c_x + 66'sd1073741823) >>> 30) : (c.c_x >>> 30);
				k_y = c.c_y[65] ? ((c.c_y + 66'sd1073741823) >>> 30) : (c.c_y >>> 30);
				v_x = c.strip_b ? 66'(c.vb_x) : 66'(c.va_x);
				v_y = c.strip_b ? 66'(c.vb_y) : 66'(c.va_y);
				r_x = sat32(v_x - k_x);
				r_y = sat32(v_y - k_y);
				if (c.strip_on && !c.sq_zero && c.dot_pos) begin
					if (c.strip_b) begin
						c.vb_x = r_x;
						c.vb_y = r_y;
					end else begin
						c.va_x = r_x;
						c.va_y = r_y;
					end
				end
				nxt[g] = c;
			end
		end else if (g == ST_DIFF) begin : g_diff
			// velocity difference for the momentum blend
			always_comb begin
				ctx_t c;
				c      = stg_s[g-1];
				c.d_x  = 33'(c.vb_x) - 33'(c.va_x);
				c.d_y  = 33'(c.vb_y) - 33'(c.va_y);
				nxt[g] = c;
			end
		end else if (g == ST_BMUL) begin : g_bmul
			// difference times weight
			always_comb begin
				ctx_t c;
				c      = stg_s[g-1];
				c.b_x  = 66'(c.d_x) * 66'($signed({1'b0, c.w}));
				c.b_y  = 66'(c.d_y) * 66'($signed({1'b0, c.w}));
				nxt[g] = c;
			end
		end else begin : g_out
			// common velocity for dynamic bodies
			always_comb begin
				ctx_t               c;
				logic signed [65:0] e_x;
				logic signed [65:0] e_y;
				logic signed [31:0] m_x;
				logic signed [31:0] m_y;
				c   = stg_s[g-1];
				e_x = c.b_x[65] ? ((c.b_x + 66'sd2147483647) >>> 31) : (c.b_x >>> 31);
				e_y = c.b_y[65] ? ((c.b_y + 66'sd2147483647) >>> 31) : (c.b_y >>> 31);
				m_x = sat32(66'(c.va_x) + e_x);
				m_y = sat32(66'(c.va_y) + e_y);
				if (c.has_both) begin
					if (c.mov_a) begin
						c.va_x = m_x;
						c.va_y = m_y;
					end
					if (c.mov_b) begin
						c.vb_x = m_x;
						c.vb_y = m_y;
					end
				end
				nxt[g] = c;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N_STG-1:1], in_valid};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 1; i <= N_STG; i++)
				stg_s[i] <= nxt[i];
		end
	end

	// output beat
	assign out_valid   = vld_s[N_STG];
	assign new_vel_a_x = stg_s[N_STG].va_x;
	assign new_vel_a_y = stg_s[N_STG].va_y;
	assign new_vel_b_x = stg_s[N_STG].vb_x;
	assign new_vel_b_y = stg_s[N_STG].vb_y;
	assign shift_a_x   = stg_s[N_STG].sh_ax;
	assign shift_a_y   = stg_s[N_STG].sh_ay;
	assign shift_b_x   = stg_s[N_STG].sh_bx;
	assign shift_b_y   = stg_s[N_STG].sh_by;

	// assertions
	`CCRU_ASSERT_NXT(a_freeze, clk, arst_n, vld_s[N_STG] && out_stall, $stable(vld_s))
	`CCRU_ASSERT_NXT(a_enter, clk, arst_n, in_valid && !in_stall, vld_s[1])
	`CCRU_ASSERT_IMP(a_noshift, clk, arst_n,
		out_valid && !stg_s[N_STG].mov_a && !stg_s[N_STG].mov_b,
		shift_a_x == 32'sd0 && shift_a_y == 32'sd0 && shift_b_x == 32'sd0 && shift_b_y == 32'sd0)

endmodule

FILE: tb/tb_contact_collision_response_unit.sv
// ----------------------------------------------------------------------------
// tb_contact_collision_response_unit
// Self-checking testbench for the contact collision response pipeline. Contacts
// are queued by a stimulus process and sent one beat at a time by a driver.
// The stimulus is a directed set followed by random contacts. A monitor checks
// every output beat, field by field, against a predictor that works out the
// same normal strip, position split and momentum blend at full width. Both
// sides idle at random, and once the output is held back for a long stretch.
// ----------------------------------------------------------------------------
module tb_contact_collision_response_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ccru_pkg::*;

	localparam int LATENCY = 73;
	localparam int N_RANDOM = 1930;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [31:0] va_x;
		logic signed [31:0] va_y;
		logic signed [31:0] vb_x;
		logic signed [31:0] vb_y;
		logic [31:0]        m_a;
		logic [31:0]        m_b;
		logic [1:0]         k_a;
		logic [1:0]         k_b;
		logic [1:0]         s_a;
		logic [1:0]         s_b;
		logic signed [31:0] t_x;
		logic signed [31:0] t_y;
	} contact_t;

	// new_vel_a x/y, new_vel_b x/y, shift_a x/y, shift_b x/y
	typedef logic [7:0][31:0] response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] vel_a_x = '0, vel_a_y = '0, vel_b_x = '0, vel_b_y = '0;
	logic [31:0] mass_a = '0, mass_b = '0;
	logic [1:0] kind_a = '0, kind_b = '0, shape_a = '0, shape_b = '0;
	logic signed [31:0] mtv_x = '0, mtv_y = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [31:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;
	logic signed [31:0] shift_a_x, shift_a_y, shift_b_x, shift_b_y;

	contact_t pending_contacts[$];
	response_t expected_responses[$];
	contact_t contact_on_bus;
	int send_idle_pct = 18;
	int recv_idle_pct = 82;
	int beats_in = 0;
	int beats_out = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	contact_collision_response_unit DUT (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// drop the velocity part that points into the normal
	function automatic void strip_into_normal(inout longint vx, inout longint vy,
			input longint sx, input longint sy);
		longint unsigned ax, ay, sq;
		longint len, nx, ny, dot, into, cx, cy;
		ax = sx < 0 ? -sx : sx;
		ay = sy < 0 ? -sy : sy;
		sq = ax * ax + ay * ay;
		if (sq == 0)
			return;
		len = longint'(int_sqrt(sq));
		nx = (sx * (64'sd1 << 30)) / len;
		ny = (sy * (64'sd1 << 30)) / len;
		dot = vx * nx + vy * ny;
		if (dot <= 0)
			return;
		into = dot >>> 30;
		cx = (nx * into) / (64'sd1 << 30);
		cy = (ny * into) / (64'sd1 << 30);
		vx = clamp32(vx - cx);
		vy = clamp32(vy - cy);
	endfunction

	function automatic response_t resolve_contact(input contact_t c);
		longint vax, vay, vbx, vby, sx, sy, hx, hy, w, cx, cy;
		longint shax, shay, shbx, shby;
		longint unsigned msum;
		bit has_a, has_b, mov_a, mov_b;
		response_t r;
		vax = c.va_x; vay = c.va_y; vbx = c.vb_x; vby = c.vb_y;
		sx = c.t_x; sy = c.t_y;
		shax = 0; shay = 0; shbx = 0; shby = 0;
		has_a = c.k_a != KIND_NONE;
		has_b = c.k_b != KIND_NONE;
		if (has_a || has_b) begin
			mov_a = c.k_a == KIND_DYNAMIC;
			mov_b = c.k_b == KIND_DYNAMIC;
			// flip the separation against a rectangle
			if ((c.s_a == SHAPE_CIRCLE || c.s_a == SHAPE_RECT) && c.s_b == SHAPE_RECT) begin
				sx = clamp32(-sx);
				sy = clamp32(-sy);
			end
			if (mov_a && !mov_b)
				strip_into_normal(vax, vay, sx, sy);
			else if (mov_b && !mov_a)
				strip_into_normal(vbx, vby, clamp32(-sx), clamp32(-sy));
			// position corrections
			if (mov_a && mov_b) begin
				hx = sx / 2;
				hy = sy / 2;
				shax = -hx; shay = -hy;
				shbx = hx; shby = hy;
			end else if (mov_a) begin
				shax = clamp32(-sx);
				shay = clamp32(-sy);
			end else if (mov_b) begin
				shbx = sx;
				shby = sy;
			end
			// common velocity, restitution zero
			if (has_a && has_b) begin
				msum = longint'(c.m_a) + longint'(c.m_b);
				w = msum == 0 ? (64'sd1 << 30)
					: longint'((longint'(c.m_b) << 31) / msum);
				cx = clamp32(vax + ((vbx - vax) * w) / (64'sd1 << 31));
				cy = clamp32(vay + ((vby - vay) * w) / (64'sd1 << 31));
				if (mov_a) begin
					vax = cx; vay = cy;
				end
				if (mov_b) begin
					vbx = cx; vby = cy;
				end
			end
		end
		r[7] = vax[31:0]; r[6] = vay[31:0]; r[5] = vbx[31:0]; r[4] = vby[31:0];
		r[3] = shax[31:0]; r[2] = shay[31:0]; r[1] = shbx[31:0]; r[0] = shby[31:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000);
			2: return 32'($signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000);
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_mass();
		logic [31:0] m;
		case ($urandom_range(0, 3))
			0: m = $urandom;
			1: m = $urandom_range(1, 32'h0010_0000);
			2: m = $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
			default: m = $urandom_range(32'h0000_8000, 32'h0100_0000);
		endcase
		return m == 0 ? 32'd1 : m;
	endfunction

	function automatic contact_t random_contact();
		contact_t c;
		c.va_x = pick_word(); c.va_y = pick_word();
		c.vb_x = pick_word(); c.vb_y = pick_word();
		c.m_a = pick_mass(); c.m_b = pick_mass();
		c.k_a = 2'($urandom_range(0, 3)); c.k_b = 2'($urandom_range(0, 3));
		c.s_a = 2'($urandom_range(0, 3)); c.s_b = 2'($urandom_range(0, 3));
		c.t_x = pick_word(); c.t_y = pick_word();
		// mostly a real contact direction, sometimes none
		if ($urandom_range(0, 15) == 0) begin
			c.t_x = '0;
			c.t_y = '0;
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_responses.push_back(resolve_contact(contact_on_bus));
				beats_in <= beats_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_contacts.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					contact_on_bus = pending_contacts.pop_front();
					in_valid <= 1'b1;
					vel_a_x <= contact_on_bus.va_x;
					vel_a_y <= contact_on_bus.va_y;
					vel_b_x <= contact_on_bus.vb_x;
					vel_b_y <= contact_on_bus.vb_y;
					mass_a <= contact_on_bus.m_a;
					mass_b <= contact_on_bus.m_b;
					kind_a <= contact_on_bus.k_a;
					kind_b <= contact_on_bus.k_b;
					shape_a <= contact_on_bus.s_a;
					shape_b <= contact_on_bus.s_b;
					mtv_x <= contact_on_bus.t_x;
					mtv_y <= contact_on_bus.t_y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor and output stall
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		response_t got, want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				got = {new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
					shift_a_x, shift_a_y, shift_b_x, shift_b_y};
				beats_out <= beats_out + 1;
				if (expected_responses.size() == 0) begin
					$display("%0t: output beat with nothing expected", $time);
					bad++;
				end else begin
					want = expected_responses.pop_front();
					for (int i = 7; i >= 0; i--)
						if (got[i] !== want[i]) begin
							$display("%0t: field %0d expected %h actual %h",
								$time, 7 - i, want[i], got[i]);
							bad++;
						end
				end
				if (bad != 0)
					mismatches <= mismatches + bad;
			end
			// long hold-off once, to fill the pipeline
			if (!hold_done && beats_in >= 1400) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(0, 99) < recv_idle_pct;
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		contact_t c;
		// directed: every kind pairing with shapes, extremes and zero separation
		for (int ka = 0; ka < 4; ka++)
			for (int kb = 0; kb < 4; kb++) begin
				c.va_x = 32'sh0002_0000; c.va_y = -32'sh0001_8000;
				c.vb_x = -32'sh0003_0000; c.vb_y = 32'sh0000_4000;
				c.m_a = 32'h0001_0000; c.m_b = 32'h0003_0000;
				c.k_a = 2'(ka); c.k_b = 2'(kb);
				c.s_a = 2'((ka + kb) % 4); c.s_b = 2'(kb % 2 == 0 ? SHAPE_RECT : kb);
				c.t_x = 32'sh0000_8000; c.t_y = -32'sh0000_4000;
				pending_contacts.push_back(c);
			end
		c = '{va_x: 32'sh8000_0000, va_y: 32'sh7fff_ffff, vb_x: 32'sh7fff_ffff,
			vb_y: 32'sh8000_0000, m_a: 32'd1, m_b: 32'hffff_ffff,
			k_a: KIND_DYNAMIC, k_b: KIND_DYNAMIC, s_a: SHAPE_CIRCLE, s_b: SHAPE_RECT,
			t_x: 32'sh8000_0000, t_y: 32'sh7fff_ffff};
		pending_contacts.push_back(c);
		c.m_a = 32'hffff_ffff; c.m_b = 32'd1; c.k_b = 2'd1; c.s_a = SHAPE_RECT;
		pending_contacts.push_back(c);
		c.k_a = 2'd2; c.k_b = KIND_DYNAMIC; c.t_x = 32'sh8000_0000; c.t_y = 32'sh8000_0000;
		pending_contacts.push_back(c);
		c.t_x = '0; c.t_y = '0; c.k_a = KIND_DYNAMIC;
		pending_contacts.push_back(c);
		c.k_a = KIND_DYNAMIC; c.k_b = KIND_NONE; c.s_b = 2'd3;
		c.t_x = 32'sh7fff_ffff; c.t_y = 32'sh0000_0001;
		pending_contacts.push_back(c);
		for (int i = 0; i < N_RANDOM; i++)
			pending_contacts.push_back(random_contact());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// idling phases
		wait (beats_in >= 650);
		send_idle_pct = 82;
		recv_idle_pct = 18;
		wait (beats_in >= 1300);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		wait (pending_contacts.size() == 0 && !in_valid && expected_responses.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d contacts (all kind pairings, shape flips, extremes, zero",
			beats_in);
		$display("separation, long output hold) and checked %0d responses", beats_out);
		if (mismatches == 0 && expected_responses.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

endmodule
